>>> rtl/core/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types and codes for the base64 fixed length decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

   typedef struct packed {
      logic [7:0] char_code;
      logic       is_end;
   } req_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] byte_index;
      logic [7:0] byte_value;
      logic [2:0] status;
      logic       last;
   } rsp_type;

   // One queued job: up to three data bytes, or one final status.
   typedef struct packed {
      logic            kind;
      logic [1:0]      count;
      logic [7:0]      start_index;
      logic [2:0][7:0] bytes;
      logic [2:0]      status;
   } job_type;

   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_BAD_CHAR = 3'd1;
   localparam logic [2:0] ST_EARLY_PAD = 3'd2;
   localparam logic [2:0] ST_OVERFLOW = 3'd3;
   localparam logic [2:0] ST_PARTIAL  = 3'd4;
   localparam logic [2:0] ST_SHORT    = 3'd5;

endpackage

>>> rtl/core/b64d_front.sv
// ----------------------------------------------------------------------------
// b64d_front
// Classifies characters, gathers groups of four and builds output jobs.
// ----------------------------------------------------------------------------
module b64d_front
   import b64d_pkg::*;
#(
   parameter int OUT_BYTES = 32,
   parameter logic [7:0] LAST_MASK = 8'hFF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  req_type req_payload,
   input  logic    job_full,
   output logic    accept,
   output logic    job_push,
   output job_type job_data
);

   localparam int PW = $clog2(OUT_BYTES + 1);
   localparam logic [6:0] PAD_SYM = 7'd64;

   logic [2:0][6:0] sym_ff, sym_in;
   logic [1:0]      cnt_ff, cnt_in;
   logic [PW-1:0]   pos_ff, pos_in;
   logic            pad_ff, pad_in;
   logic [2:0]      err_ff, err_in;

   logic [6:0]      sym;
   logic            sym_ok;
   logic            is_ws;
   logic            p2, p3;
   logic [5:0]      c6, d6;
   logic [23:0]     x;
   logic [2:0][7:0] cand;
   logic [1:0]      wanted, n;
   logic [PW-1:0]   room;
   logic            overflow;

   // Map one character to its six-bit value, or '=' to the pad code.
   always_comb begin
      sym    = 7'd0;
      sym_ok = 1'b1;
      if (req_payload.char_code >= "A" && req_payload.char_code <= "Z") begin
         sym = 7'(req_payload.char_code - "A");
      end else if (req_payload.char_code >= "a" && req_payload.char_code <= "z") begin
         sym = 7'(req_payload.char_code - "a") + 7'd26;
      end else if (req_payload.char_code >= "0" && req_payload.char_code <= "9") begin
         sym = 7'(req_payload.char_code - "0") + 7'd52;
      end else if (req_payload.char_code == "+" || req_payload.char_code == "-") begin
         sym = 7'd62;
      end else if (req_payload.char_code == "/" || req_payload.char_code == "_") begin
         sym = 7'd63;
      end else if (req_payload.char_code == "=") begin
         sym = PAD_SYM;
      end else begin
         sym_ok = 1'b0;
      end
   end

   assign is_ws = (req_payload.char_code == 8'h20) || (req_payload.char_code == 8'h09) ||
                  (req_payload.char_code == 8'h0D) || (req_payload.char_code == 8'h0A);

   // Group decode for the completing fourth symbol.
   assign p2 = (sym_ff[2] == PAD_SYM);
   assign p3 = (sym == PAD_SYM);
   assign c6 = p2 ? 6'd0 : sym_ff[2][5:0];
   assign d6 = p3 ? 6'd0 : sym[5:0];
   assign x  = {sym_ff[0][5:0], sym_ff[1][5:0], c6, d6};

   // Compact the bytes to emit: a padded third symbol drops the middle byte.
   assign cand[0] = x[23:16];
   assign cand[1] = p2 ? x[7:0] : x[15:8];
   assign cand[2] = x[7:0];
   assign wanted  = 2'd1 + {1'b0, !p2} + {1'b0, !p3};

   assign room     = PW'(OUT_BYTES) - pos_ff;
   assign overflow = (PW+2)'(room) < (PW+2)'(wanted);
   assign n        = overflow ? 2'(room) : wanted;

   assign accept = req_valid && !job_full;

   always_comb begin
      sym_in   = sym_ff;
      cnt_in   = cnt_ff;
      pos_in   = pos_ff;
      pad_in   = pad_ff;
      err_in   = err_ff;
      job_push = 1'b0;
      job_data = '0;
      if (accept) begin
         if (req_payload.is_end) begin
            job_push       = 1'b1;
            job_data.kind  = KIND_STATUS;
            job_data.count = 2'd1;
            if (err_ff != ST_OK) begin
               job_data.status = err_ff;
            end else if (cnt_ff != 2'd0) begin
               job_data.status = ST_PARTIAL;
            end else if (pos_ff != PW'(OUT_BYTES)) begin
               job_data.status = ST_SHORT;
            end else begin
               job_data.status = ST_OK;
            end
            sym_in = '0;
            cnt_in = 2'd0;
            pos_in = '0;
            pad_in = 1'b0;
            err_in = ST_OK;
         end else if (err_ff == ST_OK && !pad_ff && !is_ws) begin
            if (!sym_ok) begin
               err_in = ST_BAD_CHAR;
            end else if (cnt_ff != 2'd3) begin
               sym_in[cnt_ff] = sym;
               cnt_in         = cnt_ff + 2'd1;
            end else begin
               sym_in = '0;
               cnt_in = 2'd0;
               if (sym_ff[0] == PAD_SYM || sym_ff[1] == PAD_SYM) begin
                  err_in = ST_EARLY_PAD;
               end else begin
                  if (overflow) begin
                     err_in = ST_OVERFLOW;
                  end else if (p2 || p3) begin
                     pad_in = 1'b1;
                  end
                  pos_in = pos_ff + PW'(n);
                  job_push             = (n != 2'd0);
                  job_data.kind        = KIND_DATA;
                  job_data.count       = n;
                  job_data.start_index = 8'(pos_ff);
                  job_data.status      = ST_OK;
                  for (int k = 0; k < 3; k++) begin
                     // Trim the final byte of the image to its used bits.
                     if ((PW+2)'(pos_ff) + (PW+2)'(k) == (PW+2)'(OUT_BYTES - 1)) begin
                        job_data.bytes[k] = cand[k] & LAST_MASK;
                     end else begin
                        job_data.bytes[k] = cand[k];
                     end
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sym_ff <= '0;
         cnt_ff <= 2'd0;
         pos_ff <= '0;
         pad_ff <= 1'b0;
         err_ff <= ST_OK;
      end else begin
         sym_ff <= sym_in;
         cnt_ff <= cnt_in;
         pos_ff <= pos_in;
         pad_ff <= pad_in;
         err_ff <= err_in;
      end
   end

endmodule

>>> rtl/core/b64d_fifo.sv
// ----------------------------------------------------------------------------
// b64d_fifo
// Small job queue between the front and back halves.
// ----------------------------------------------------------------------------
module b64d_fifo
   import b64d_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   input  logic    pop,
   output job_type head,
   output logic    full,
   output logic    empty
);

   localparam int DEPTH = 4;
   localparam int AW    = $clog2(DEPTH);

   job_type        mem_ff [DEPTH];
   logic [AW-1:0]  wr_ff, wr_in;
   logic [AW-1:0]  rd_ff, rd_in;
   logic [AW:0]    cnt_ff, cnt_in;
   logic           do_push, do_pop;

   assign full    = (cnt_ff == (AW+1)'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? wr_ff + AW'(1) : wr_ff;
      rd_in  = do_pop ? rd_ff + AW'(1) : rd_ff;
      cnt_in = cnt_ff + (AW+1)'(do_push) - (AW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

>>> rtl/core/b64d_back.sv
// ----------------------------------------------------------------------------
// b64d_back
// Unrolls queued jobs into one registered result per transfer.
// ----------------------------------------------------------------------------
module b64d_back
   import b64d_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  job_type head,
   input  logic    empty,
   output logic    pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   logic       valid_ff, valid_in;
   rsp_type    out_ff, out_in;
   logic [1:0] sub_ff, sub_in;
   logic       load;
   logic       final_elem;

   assign load       = !valid_ff || !rsp_stall;
   assign final_elem = (sub_ff == head.count - 2'd1);
   assign pop        = load && !empty && final_elem;

   always_comb begin
      valid_in = valid_ff;
      out_in   = out_ff;
      sub_in   = sub_ff;
      if (load) begin
         valid_in = !empty;
         if (!empty) begin
            sub_in = final_elem ? 2'd0 : sub_ff + 2'd1;
            out_in.kind = head.kind;
            out_in.last = final_elem;
            if (head.kind == KIND_STATUS) begin
               out_in.byte_index = 8'd0;
               out_in.byte_value = 8'd0;
               out_in.status     = head.status;
            end else begin
               out_in.byte_index = head.start_index + 8'(sub_ff);
               out_in.byte_value = head.bytes[sub_ff];
               out_in.status     = ST_OK;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      if (reset) begin
         valid_ff <= 1'b0;
         sub_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         sub_ff   <= sub_in;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = out_ff;

endmodule

>>> rtl/core/base64_fixed_length_decoder.sv
// ----------------------------------------------------------------------------
// base64_fixed_length_decoder
// Streaming base64 decoder into a fixed-length byte image.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle while the job queue has room; the result
//   side moves one result per cycle while rsp_stall is low, through the single
//   output register of the back half. Path: the character that completes a
//   group writes its job into the queue, and the back half then registers
//   each result from the queue head into its output register.
// Reset: synchronous; clears decode state, queue pointers and output valid.
// ----------------------------------------------------------------------------
module base64_fixed_length_decoder
   import b64d_pkg::*;
#(
   parameter int OUT_BYTES  = 32,
   parameter int TOTAL_BITS = 256
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   // Bits of the final byte that fall inside the image.
   localparam int ALL_BITS    = OUT_BYTES * 8;
   localparam int UNUSED_BITS = (TOTAL_BITS >= ALL_BITS) ? 0 : ALL_BITS - TOTAL_BITS;
   localparam logic [7:0] LAST_MASK =
      (UNUSED_BITS >= 8) ? 8'h00 : 8'((1 << (8 - UNUSED_BITS)) - 1);

   logic    accept;
   logic    job_push;
   job_type job_data;
   job_type job_head;
   logic    job_full;
   logic    job_empty;
   logic    job_pop;

   // Front: classify characters, gather groups, hold decode state.
   b64d_front #(
      .OUT_BYTES (OUT_BYTES),
      .LAST_MASK (LAST_MASK)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .job_full    (job_full),
      .accept      (accept),
      .job_push    (job_push),
      .job_data    (job_data)
   );

   // Stall the input only when the job queue has no room.
   assign req_stall = job_full;

   // Queue: decouple group decode from result unrolling.
   b64d_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push && accept),
      .push_data (job_data),
      .pop       (job_pop),
      .head      (job_head),
      .full      (job_full),
      .empty     (job_empty)
   );

   // Back: advance through each job one result per transfer.
   b64d_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (job_head),
      .empty       (job_empty),
      .pop         (job_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
